// File: hdl/etmb_pkg.sv
// Package with shared types, constants and arithmetic helpers for the TRS matrix builder.
package etmb_pkg;

  localparam int unsigned SinC1 = 32'd1686629713;
  localparam int unsigned SinC3 = 32'd693598669;
  localparam int unsigned SinC5 = 32'd85569304;
  localparam int unsigned SinC7 = 32'd5026995;
  localparam int unsigned SinC9 = 32'd172272;

  localparam logic [1:0] OP_MODEL  = 2'd0;
  localparam logic [1:0] OP_ROTSC  = 2'd1;
  localparam logic [1:0] OP_NORMAL = 2'd2;

  localparam logic signed [31:0] Int32Max = 32'sh7FFF_FFFF;
  localparam int RecipStages = 26;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] col3_x;
    logic signed [31:0] col3_y;
    logic signed [31:0] col3_z;
  } out_beat_t;

  // Division of a signed 96-bit value by 2^n, rounded half up (floor of v / 2^n + 1/2).
  function automatic logic signed [95:0] rshift(input logic signed [95:0] v, input int n);
    logic [95:0] mag;
    logic [95:0] r;
    begin
      mag = v[95] ? 96'(-v) : 96'(v);
      if (!v[95]) begin
        r = (mag + (96'd1 << (n - 1))) >> n;
        rshift = $signed(r);
      end else begin
        r = (mag + (96'd1 << (n - 1)) - 96'd1) >> n;
        rshift = -$signed(r);
      end
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    begin
      if (v > 96'sh7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
      else if (v < -96'sh8000_0000) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

// File: hdl/etmb_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface etmb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/euler_trs_matrix_builder_unit.sv
// Top level of the pipelined Euler TRS matrix builder.
//  channel | dir | payload           | handshake
//  in_if   | in  | etmb_pkg::in_beat_t  | valid/ready
//  out_if  | out | etmb_pkg::out_beat_t | valid/ready
// One beat may enter every cycle while the pipe advances; a beat passes seven sine stages, three
// rotation stages, a divider set-up stage, 26 reciprocal divider stages and the output
// register.
// Reset clears only the valid bits; payload registers are not reset.
// A stall holds every stage in place: the whole pipe advances when the last stage
// is empty or its beat is taken.
module euler_trs_matrix_builder_unit (
  input logic clk_i,
  input logic rst_ni,
  etmb_stream_if.sink   in_if,
  etmb_stream_if.source out_if
);

  localparam int SinSt = 7;
  localparam int RotSt = 3;
  localparam int RcpSt = etmb_pkg::RecipStages;
  localparam int Depth = SinSt + RotSt + RcpSt + 2;

  logic adv;
  logic [Depth-1:0] vld_q;

  assign adv = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_q[Depth-1];

  // Valid bits travel along the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // Payload delay line alongside the arithmetic.
  etmb_pkg::in_beat_t beat_q [Depth];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      beat_q[0] <= in_if.data;
      for (int i = 1; i < Depth; i++) beat_q[i] <= beat_q[i-1];
    end
  end

  // Sine units: six angles, quadrant folded in stage 0, Horner steps after, sign applied last.
  logic [15:0] ang [6];
  assign ang[0] = in_if.data.angle_y;
  assign ang[1] = in_if.data.angle_y + 16'd16384;
  assign ang[2] = in_if.data.angle_x;
  assign ang[3] = in_if.data.angle_x + 16'd16384;
  assign ang[4] = in_if.data.angle_z;
  assign ang[5] = in_if.data.angle_z + 16'd16384;

  logic [31:0] x_q  [SinSt][6];
  logic [31:0] x2_q [SinSt][6];
  logic [31:0] p_q  [SinSt][6];
  logic        ng_q [SinSt][6];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        logic [14:0] t;
        logic [63:0] xx;
        t = ang[k][14] ? 15'(15'd16384 - {1'b0, ang[k][13:0]}) : {1'b0, ang[k][13:0]};
        xx = {17'd0, t, 16'd0} * {17'd0, t, 16'd0};
        x_q[0][k]  <= {1'b0, t, 16'd0};
        x2_q[0][k] <= 32'(xx >> 30);
        p_q[0][k]  <= etmb_pkg::SinC9;
        ng_q[0][k] <= ang[k][15];
      end
      for (int s = 1; s < 5; s++) begin
        for (int k = 0; k < 6; k++) begin
          logic [63:0] pr;
          logic [31:0] c;
          pr = {32'd0, p_q[s-1][k]} * {32'd0, x2_q[s-1][k]};
          c = (s == 1) ? etmb_pkg::SinC7 : (s == 2) ? etmb_pkg::SinC5 :
              (s == 3) ? etmb_pkg::SinC3 : etmb_pkg::SinC1;
          p_q[s][k]  <= c - 32'(pr >> 30);
          x_q[s][k]  <= x_q[s-1][k];
          x2_q[s][k] <= x2_q[s-1][k];
          ng_q[s][k] <= ng_q[s-1][k];
        end
      end
      for (int k = 0; k < 6; k++) begin
        logic [63:0] pr;
        logic [31:0] r;
        pr = {32'd0, p_q[4][k]} * {32'd0, x_q[4][k]};
        r = 32'(((pr >> 30) + 64'd8192) >> 14);
        if (r > 32'd65536) r = 32'd65536;
        p_q[5][k]  <= r;
        ng_q[5][k] <= ng_q[4][k];
        x_q[5][k]  <= '0;
        x2_q[5][k] <= '0;
        p_q[6][k]  <= ng_q[5][k] ? 32'(-p_q[5][k]) : p_q[5][k];
        x_q[6][k]  <= '0;
        x2_q[6][k] <= '0;
        ng_q[6][k] <= 1'b0;
      end
    end
  end

  logic signed [17:0] s1, c1, s2, c2, s3, c3;
  assign s1 = 18'(p_q[6][0]); assign c1 = 18'(p_q[6][1]);
  assign s2 = 18'(p_q[6][2]); assign c2 = 18'(p_q[6][3]);
  assign s3 = 18'(p_q[6][4]); assign c3 = 18'(p_q[6][5]);

  // Rotation: pair products, then triple products, then rounding.
  logic signed [35:0] pp_q [6];
  logic signed [17:0] t3_q [6];
  logic signed [35:0] dp_q [4];
  logic signed [95:0] tr_q [8];
  logic signed [17:0] rot_q [9];
  logic signed [17:0] s2d_q, s2e_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q[0] <= c1 * c3; pp_q[1] <= s1 * s2; pp_q[2] <= c3 * s1;
      pp_q[3] <= c1 * s3; pp_q[4] <= c1 * s2; pp_q[5] <= s1 * s3;
      t3_q[0] <= s3; t3_q[1] <= s2; t3_q[2] <= c2; t3_q[3] <= c3;
      t3_q[4] <= s1; t3_q[5] <= c1;
      s2d_q <= s2;
      tr_q[0] <= 96'(pp_q[0]) <<< 16;
      tr_q[1] <= 96'(pp_q[1] * t3_q[0]);
      tr_q[2] <= 96'(pp_q[2] * t3_q[1]);
      tr_q[3] <= 96'(pp_q[3]) <<< 16;
      tr_q[4] <= 96'(pp_q[4] * t3_q[0]);
      tr_q[5] <= 96'(pp_q[2]) <<< 16;
      tr_q[6] <= 96'(pp_q[0] * t3_q[1]);
      tr_q[7] <= 96'(pp_q[5]) <<< 16;
      // Products with c2 are formed here and rounded with the others below.
      dp_q[0] <= t3_q[2] * t3_q[4];
      dp_q[1] <= t3_q[2] * t3_q[0];
      dp_q[2] <= t3_q[2] * t3_q[3];
      dp_q[3] <= t3_q[2] * t3_q[5];
      s2e_q <= s2d_q;
      rot_q[0] <= 18'(etmb_pkg::rshift(tr_q[0] + tr_q[1], 32));
      rot_q[1] <= 18'(etmb_pkg::rshift(tr_q[2] - tr_q[3], 32));
      rot_q[2] <= 18'(etmb_pkg::rshift(96'(dp_q[0]), 16));
      rot_q[3] <= 18'(etmb_pkg::rshift(96'(dp_q[1]), 16));
      rot_q[4] <= 18'(etmb_pkg::rshift(96'(dp_q[2]), 16));
      rot_q[5] <= -s2e_q;
      rot_q[6] <= 18'(etmb_pkg::rshift(tr_q[4] - tr_q[5], 32));
      rot_q[7] <= 18'(etmb_pkg::rshift(tr_q[6] + tr_q[7], 32));
      rot_q[8] <= 18'(etmb_pkg::rshift(96'(dp_q[3]), 16));
    end
  end

  // Reciprocal: restoring division, one quotient bit per stage, three lanes.
  logic [25:0] num_q [RcpSt+1][3];
  logic [25:0] rem_q [RcpSt+1][3];
  logic [25:0] quo_q [RcpSt+1][3];
  logic [15:0] den_q [RcpSt+1][3];
  logic signed [17:0] rotd_q [RcpSt+1][9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [15:0] sc;
        logic [15:0] m;
        sc = (k == 0) ? beat_q[SinSt+RotSt-1].scale_x :
             (k == 1) ? beat_q[SinSt+RotSt-1].scale_y : beat_q[SinSt+RotSt-1].scale_z;
        m = sc[15] ? 16'(-sc) : 16'(sc);
        num_q[0][k] <= 26'((25'd1 << 24) + 25'(m >> 1));
        den_q[0][k] <= m;
        rem_q[0][k] <= '0;
        quo_q[0][k] <= '0;
      end
      for (int j = 0; j < 9; j++) rotd_q[0][j] <= rot_q[j];
      for (int s = 1; s <= RcpSt; s++) begin
        for (int k = 0; k < 3; k++) begin
          logic [26:0] r;
          r = {rem_q[s-1][k], num_q[s-1][k][25 - (s - 1)]};
          if (r >= {11'd0, den_q[s-1][k]}) begin
            rem_q[s][k] <= 26'(r - {11'd0, den_q[s-1][k]});
            quo_q[s][k] <= quo_q[s-1][k] | (26'd1 << (26 - s));
          end else begin
            rem_q[s][k] <= r[25:0];
            quo_q[s][k] <= quo_q[s-1][k];
          end
          num_q[s][k] <= num_q[s-1][k];
          den_q[s][k] <= den_q[s-1][k];
        end
        for (int j = 0; j < 9; j++) rotd_q[s][j] <= rotd_q[s-1][j];
      end
    end
  end

  // Final scaling and saturation, one output register.
  etmb_pkg::out_beat_t res_q;
  etmb_pkg::in_beat_t  bt;
  assign bt = beat_q[Depth-2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [31:0] f [3];
      logic signed [15:0] sc [3];
      logic signed [31:0] r [9];
      sc[0] = bt.scale_x; sc[1] = bt.scale_y; sc[2] = bt.scale_z;
      for (int k = 0; k < 3; k++) begin
        if (sc[k] == 16'sd0) f[k] = etmb_pkg::Int32Max;
        else f[k] = sc[k][15] ? -$signed({6'd0, quo_q[RcpSt][k]})
                              : $signed({6'd0, quo_q[RcpSt][k]});
      end
      for (int j = 0; j < 9; j++) begin
        if (bt.opcode == etmb_pkg::OP_NORMAL)
          r[j] = etmb_pkg::sat32(etmb_pkg::rshift(96'(f[j%3] * rotd_q[RcpSt][j]), 16));
        else
          r[j] = etmb_pkg::sat32(etmb_pkg::rshift(96'(sc[j%3] * rotd_q[RcpSt][j]), 8));
      end
      res_q.m00 <= r[0]; res_q.m01 <= r[1]; res_q.m02 <= r[2];
      res_q.m10 <= r[3]; res_q.m11 <= r[4]; res_q.m12 <= r[5];
      res_q.m20 <= r[6]; res_q.m21 <= r[7]; res_q.m22 <= r[8];
      res_q.col3_x <= (bt.opcode == etmb_pkg::OP_MODEL) ? bt.shift_x : 32'sd0;
      res_q.col3_y <= (bt.opcode == etmb_pkg::OP_MODEL) ? bt.shift_y : 32'sd0;
      res_q.col3_z <= (bt.opcode == etmb_pkg::OP_MODEL) ? bt.shift_z : 32'sd0;
    end
  end
  assign out_if.data = res_q;

endmodule
